FILE: rtl/asa_pkg.sv
// shared types and constants for the aliquot sum abundance classifier
`timescale 1ns / 1ps

package asa_pkg;

    // default datapath width for the number under test
    localparam int NUM_WIDTH_DEF = 16;

    // fixed field widths on the streams
    localparam int NUMBER_WIDTH  = 16;
    localparam int ABUND_WIDTH   = 19;
    localparam int CLASS_WIDTH   = 2;
    localparam int S_TDATA_WIDTH = 16;
    localparam int M_TDATA_WIDTH = 24;

    // saturation limits of the abundance field
    localparam int ABUND_MAX = 262143;
    localparam int ABUND_MIN = -262144;

    // class codes
    typedef enum logic [CLASS_WIDTH-1:0] {
        CLASS_DEFICIENT = 2'd0,
        CLASS_PERFECT   = 2'd1,
        CLASS_ABUNDANT  = 2'd2
    } class_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // status from the remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_status_t;

endpackage

FILE: rtl/asa_rem_unit.sv
// shared restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module asa_rem_unit #(
    parameter int WIDTH = asa_pkg::NUM_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output asa_pkg::rem_status_t status
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH:0]   trial;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[WIDTH-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = WIDTH'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[WIDTH-1:0];
            end
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

    // a start never lands on a division in progress
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("remainder unit restarted while busy");

    // done follows the last step exactly
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && cnt_reg == LAST_STEP) |=> done_reg)
        else $error("remainder unit missed done");

    // the remainder is below the divisor once done
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dsr_reg)) else $error("remainder not reduced");

endmodule

FILE: rtl/aliquot_sum_abundance_top.sv
// top level: proper divisor sum by trial division, abundance and class
`timescale 1ns / 1ps

// Takes one unsigned number per item on the s_axis side and returns its
// abundance (sum of proper divisors minus the number, 19-bit two's
// complement, saturated) and a class code (deficient, perfect, abundant) on
// the m_axis side. Every candidate divisor from 1 to number minus one is
// tested on one shared restoring remainder unit that retires one bit a
// cycle. Inputs 0 and 1 skip the remainder unit. Only the low NUM_WIDTH
// bits of the number are used. s_axis_tready is high only while no item is
// in work; a finished result sits in an output register until taken, and
// the next item can be accepted as soon as the result has moved there.
module aliquot_sum_abundance_top #(
    parameter int NUM_WIDTH = asa_pkg::NUM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] number
    input  logic [asa_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [18:0] abundance, [20:19] number_class, [23:21] zero
    output logic [asa_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata
);

    localparam int IN_W  = (NUM_WIDTH < asa_pkg::NUMBER_WIDTH) ?
                           NUM_WIDTH : asa_pkg::NUMBER_WIDTH;
    localparam int SUM_W  = NUM_WIDTH + 3;
    localparam int DIFF_W = SUM_W + 1;
    localparam int EXT_W  = (DIFF_W > asa_pkg::ABUND_WIDTH) ? DIFF_W : asa_pkg::ABUND_WIDTH;
    localparam int PAD_W  = asa_pkg::M_TDATA_WIDTH - asa_pkg::ABUND_WIDTH
                            - asa_pkg::CLASS_WIDTH;
    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(asa_pkg::ABUND_MAX);
    localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(asa_pkg::ABUND_MIN);

    asa_pkg::state_t state_reg, state_next;

    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] cand_reg, cand_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    logic                               out_valid_reg, out_valid_next;
    logic [asa_pkg::ABUND_WIDTH-1:0]    abund_reg, abund_next;
    asa_pkg::class_t                    class_reg, class_next;

    logic                 s_fire;
    logic                 div_start;
    logic                 out_free;
    logic                 load_out;
    asa_pkg::rem_status_t rem_sts;

    logic signed [DIFF_W-1:0] diff;
    logic signed [EXT_W-1:0]  diff_ext;
    asa_pkg::class_t          diff_class;
    logic [asa_pkg::ABUND_WIDTH-1:0] diff_sat;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // shared remainder unit
    asa_rem_unit #(
        .WIDTH (NUM_WIDTH)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (cand_reg),
        .status   (rem_sts)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            asa_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = asa_pkg::ST_CHECK;
                end
            end
            asa_pkg::ST_CHECK: begin
                if (cand_reg >= n_reg) begin
                    state_next = asa_pkg::ST_FINISH;
                end else begin
                    state_next = asa_pkg::ST_WAIT;
                end
            end
            asa_pkg::ST_WAIT: begin
                if (rem_sts.done) begin
                    state_next = asa_pkg::ST_CHECK;
                end
            end
            asa_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = asa_pkg::ST_IDLE;
                end
            end
            default: state_next = asa_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            asa_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            asa_pkg::ST_CHECK:  div_start     = (cand_reg < n_reg);
            asa_pkg::ST_WAIT:   ;
            asa_pkg::ST_FINISH: load_out      = out_free;
            default:            ;
        endcase
    end

    // abundance, class from the true sign, then saturation
    assign diff     = signed'({1'b0, sum_reg}) - signed'(DIFF_W'(n_reg));
    assign diff_ext = EXT_W'(diff);

    always_comb begin
        priority if (diff < 0) begin
            diff_class = asa_pkg::CLASS_DEFICIENT;
        end else if (diff == 0) begin
            diff_class = asa_pkg::CLASS_PERFECT;
        end else begin
            diff_class = asa_pkg::CLASS_ABUNDANT;
        end
        priority if (diff_ext > SAT_MAX) begin
            diff_sat = SAT_MAX[asa_pkg::ABUND_WIDTH-1:0];
        end else if (diff_ext < SAT_MIN) begin
            diff_sat = SAT_MIN[asa_pkg::ABUND_WIDTH-1:0];
        end else begin
            diff_sat = diff_ext[asa_pkg::ABUND_WIDTH-1:0];
        end
    end

    // datapath next values
    always_comb begin
        n_next         = n_reg;
        cand_next      = cand_reg;
        sum_next       = sum_reg;
        abund_next     = abund_reg;
        class_next     = class_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_fire) begin
            n_next    = NUM_WIDTH'(s_axis_tdata[IN_W-1:0]);
            cand_next = NUM_WIDTH'(1);
            sum_next  = '0;
        end
        // accumulate a candidate that divides evenly, then move on
        if (state_reg == asa_pkg::ST_WAIT && rem_sts.done) begin
            if (rem_sts.rem_zero) begin
                sum_next = sum_reg + SUM_W'(cand_reg);
            end
            cand_next = cand_reg + 1'b1;
        end
        if (load_out) begin
            abund_next     = diff_sat;
            class_next     = diff_class;
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= asa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        cand_reg  <= cand_next;
        sum_reg   <= sum_next;
        abund_reg <= abund_next;
        class_reg <= class_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, class_reg, abund_reg};

    // the remainder unit reports only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_sts.done |-> state_reg == asa_pkg::ST_WAIT)
        else $error("remainder result outside wait state");

    // an accepted item starts with the candidate check
    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == asa_pkg::ST_CHECK && cand_reg == NUM_WIDTH'(1)))
        else $error("item not started correctly");

    // candidates under test stay below the number
    a_cand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == asa_pkg::ST_WAIT |-> (cand_reg < n_reg && cand_reg != '0))
        else $error("candidate out of range");

    // an unread result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule

FILE: tb/sv/tb_aliquot_sum_abundance_top.sv
// testbench for the aliquot sum abundance classifier: directed table, random numbers, self-check
`timescale 1ns / 1ps

module tb_aliquot_sum_abundance_top;

    import asa_pkg::*;

    localparam int N_RANDOM       = 100;
    localparam int N_FAST_ITEMS   = 20;        // first random items run with no gaps
    localparam int TAIL_CYCLES    = 50;
    localparam int WATCHDOG_LIMIT = 6_000_000; // long enough for the largest number
    localparam int PAD_LSB        = ABUND_WIDTH + CLASS_WIDTH;

    // one expected or observed result, with the number that caused it
    typedef struct {
        logic [NUMBER_WIDTH-1:0]       number;
        logic signed [ABUND_WIDTH-1:0] abundance;
        class_t                        number_class;
    } abundance_t;

    // one row of the directed table; typed rows carry their result
    typedef struct {
        logic [NUMBER_WIDTH-1:0]       number;
        bit                            typed;
        logic signed [ABUND_WIDTH-1:0] abundance;
        class_t                        number_class;
    } directed_row_t;

    localparam int N_DIRECTED = 17;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_WIDTH-1:0] s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

    abundance_t pending_results[$];
    bit         no_gaps = 1'b0;
    int         error_count = 0;
    int         numbers_sent = 0;
    int         results_checked = 0;
    int         class_seen[3] = '{0, 0, 0};
    int         idle_cycles = 0;

    directed_row_t directed_rows[N_DIRECTED] = '{
        '{16'd0,     1'b1, 19'sd0,  CLASS_PERFECT},
        '{16'd1,     1'b1, -19'sd1, CLASS_DEFICIENT},
        '{16'd2,     1'b1, -19'sd1, CLASS_DEFICIENT},
        '{16'd3,     1'b0, 19'sd0,  CLASS_DEFICIENT},
        '{16'd4,     1'b0, 19'sd0,  CLASS_DEFICIENT},
        '{16'd6,     1'b1, 19'sd0,  CLASS_PERFECT},
        '{16'd12,    1'b1, 19'sd4,  CLASS_ABUNDANT},
        '{16'd28,    1'b1, 19'sd0,  CLASS_PERFECT},
        '{16'd97,    1'b0, 19'sd0,  CLASS_DEFICIENT},
        '{16'd496,   1'b1, 19'sd0,  CLASS_PERFECT},
        '{16'd720,   1'b0, 19'sd0,  CLASS_DEFICIENT},
        '{16'd945,   1'b0, 19'sd0,  CLASS_DEFICIENT},
        '{16'd1024,  1'b0, 19'sd0,  CLASS_DEFICIENT},
        '{16'd0,     1'b1, 19'sd0,  CLASS_PERFECT},
        '{16'd1,     1'b1, -19'sd1, CLASS_DEFICIENT},
        '{16'd255,   1'b0, 19'sd0,  CLASS_DEFICIENT},
        '{16'd65535, 1'b0, 19'sd0,  CLASS_DEFICIENT}
    };

    aliquot_sum_abundance_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // sum of proper divisors minus the number, saturated, class from the true sign
    function automatic abundance_t predict_abundance(input logic [NUMBER_WIDTH-1:0] number);
        abundance_t result;
        longint     n;
        longint     divisor;
        longint     divisor_sum;
        longint     diff;
        n = longint'(number) & ((longint'(1) << NUM_WIDTH_DEF) - 1);
        divisor_sum = 0;
        for (divisor = 1; divisor < n; divisor++) begin
            if (n % divisor == 0) begin
                divisor_sum += divisor;
            end
        end
        diff = divisor_sum - n;
        result.number = number;
        if (diff < 0) begin
            result.number_class = CLASS_DEFICIENT;
        end else if (diff == 0) begin
            result.number_class = CLASS_PERFECT;
        end else begin
            result.number_class = CLASS_ABUNDANT;
        end
        if (diff > ABUND_MAX) begin
            diff = ABUND_MAX;
        end
        if (diff < ABUND_MIN) begin
            diff = ABUND_MIN;
        end
        result.abundance = diff[ABUND_WIDTH-1:0];
        return result;
    endfunction

    // gap before the next item: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 40) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // random number: mostly small so each item stays short, some mid sized
    function automatic logic [NUMBER_WIDTH-1:0] pick_number();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return NUMBER_WIDTH'($urandom_range(0, 15));
        end else if (roll < 88) begin
            return NUMBER_WIDTH'($urandom_range(0, 300));
        end
        return NUMBER_WIDTH'($urandom_range(301, 1200));
    endfunction

    // offer one item and wait for it to be taken, then queue its result
    task automatic send_number(input logic [NUMBER_WIDTH-1:0] number,
                               input abundance_t expected);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tdata  <= number;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_results.push_back(expected);
        numbers_sent++;
    endtask

    // result side pacing
    always @(posedge aclk) begin : ready_pacer
        int stall_left;
        int roll;
        if (!aresetn) begin
            stall_left = 0;
            m_axis_tready <= 1'b0;
        end else if (no_gaps) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                m_axis_tready <= 1'b1;
            end else if (roll < 85) begin
                stall_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = $urandom_range(8, 60);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge aclk) begin : result_check
        abundance_t                    want;
        logic signed [ABUND_WIDTH-1:0] got_abundance;
        logic [CLASS_WIDTH-1:0]        got_class;
        logic [M_TDATA_WIDTH-PAD_LSB-1:0] got_pad;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_abundance = m_axis_tdata[ABUND_WIDTH-1:0];
            got_class     = m_axis_tdata[ABUND_WIDTH +: CLASS_WIDTH];
            got_pad       = m_axis_tdata[M_TDATA_WIDTH-1:PAD_LSB];
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending: abundance %0d class %0d",
                         $time, got_abundance, got_class);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got_abundance !== want.abundance) begin
                    $display("%0t: number %0d abundance: expected %0d, actual %0d",
                             $time, want.number, want.abundance, got_abundance);
                    error_count++;
                end
                if (got_class !== want.number_class) begin
                    $display("%0t: number %0d class: expected %0d, actual %0d",
                             $time, want.number, want.number_class, got_class);
                    error_count++;
                end
                if (got_pad !== '0) begin
                    $display("%0t: number %0d pad bits: expected 0, actual %0h",
                             $time, want.number, got_pad);
                    error_count++;
                end
                if (want.number_class <= CLASS_ABUNDANT) begin
                    class_seen[want.number_class]++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results still pending",
                         $time, pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // reset, directed table, random numbers, drain
    initial begin : stimulus
        abundance_t              expected;
        logic [NUMBER_WIDTH-1:0] number;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int row = 0; row < N_DIRECTED; row++) begin
            if (directed_rows[row].typed) begin
                expected.number       = directed_rows[row].number;
                expected.abundance    = directed_rows[row].abundance;
                expected.number_class = directed_rows[row].number_class;
            end else begin
                expected = predict_abundance(directed_rows[row].number);
            end
            send_number(directed_rows[row].number, expected);
        end

        // random numbers, the first stretch with no idling on either side
        for (int idx = 0; idx < N_RANDOM; idx++) begin
            no_gaps = (idx < N_FAST_ITEMS);
            number = pick_number();
            send_number(number, predict_abundance(number));
        end
        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b0;

        // drain and let the block settle
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d numbers (directed edge cases, 0..65535 extremes, random mix)",
                 numbers_sent);
        $display("checked %0d results: %0d deficient, %0d perfect, %0d abundant",
                 results_checked, class_seen[CLASS_DEFICIENT], class_seen[CLASS_PERFECT],
                 class_seen[CLASS_ABUNDANT]);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/asa_pkg.sv
rtl/asa_rem_unit.sv
rtl/aliquot_sum_abundance_top.sv
tb/sv/tb_aliquot_sum_abundance_top.sv
